FILE: rtl/turing_machine_step_with_loop_detect_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Turing machine stepper
// Each macro expands to a labeled concurrent assertion on clk, disabled in
// reset, or to nothing when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef TURING_MACHINE_STEP_WITH_LOOP_DETECT_TOP_ASSERT_SVH
`define TURING_MACHINE_STEP_WITH_LOOP_DETECT_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define TMS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tms assertion failed");
// Next-cycle implication.
`define TMS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tms assertion failed");
`else
`define TMS_ASSERT_NOW(name, ante, cons)
`define TMS_ASSERT_NEXT(name, ante, cons)
`endif

`endif

FILE: rtl/tms_pkg.sv
// ----------------------------------------------------------------------------
// tms_pkg
// Shared sizes, codes, rule layout and helpers of the Turing machine stepper.
// ----------------------------------------------------------------------------
package tms_pkg;

  localparam int MAX_STATES  = 16;
  localparam int MAX_SYMBOLS = 4;
  localparam int TAPE_CELLS  = 1024;

  localparam int STATE_W    = $clog2(MAX_STATES);
  localparam int SYM_W      = $clog2(MAX_SYMBOLS);
  localparam int RULE_AW    = STATE_W + SYM_W;
  localparam int RULE_DEPTH = MAX_STATES * MAX_SYMBOLS;
  localparam int RULE_W     = STATE_W + 1 + SYM_W + 1;
  localparam int TAPE_AW    = $clog2(TAPE_CELLS);
  localparam int POS_W      = TAPE_AW;
  localparam int TAPE_HALF  = TAPE_CELLS / 2;
  localparam int CNT_W      = 5;
  localparam int CFG_W      = 5;

  typedef logic signed [POS_W-1:0] pos_t;

  localparam pos_t POS_HIGH = pos_t'(TAPE_HALF - 1);
  localparam pos_t POS_LOW  = pos_t'(-TAPE_HALF);
  localparam logic [CNT_W-1:0] RUN_MAX = '1;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_RUNNING   = 3'd0,
    ST_HALTED    = 3'd1,
    ST_SHORT_ESC = 3'd2,
    ST_LONG_ESC  = 3'd3,
    ST_TWO_CYCLE = 3'd4,
    ST_EXHAUSTED = 3'd5
  } status_t;

  typedef enum logic [0:0] {
    CFG_STATE_COUNT = 1'b0,
    CFG_BLANK       = 1'b1
  } cfg_idx_t;

  // Bit layout of one rule table entry, most significant field first.
  typedef struct packed {
    logic [STATE_W-1:0] next_state;
    logic               halts;
    logic [SYM_W-1:0]   wsym;
    logic               right;
  } rule_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic load_rule;
    logic restart;
    logic tape_rd_head;
    logic tape_rd_pos;
    logic rule_rd1;
    logic exec_step;
    logic rule_rd2;
    logic check2;
    logic respond;
  } tms_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    opcode_t op;
    logic    running;
    logic    need_second;
  } tms_stat_t;

  // Tape position to memory address: position p lives at p + TAPE_HALF.
  function automatic logic [TAPE_AW-1:0] tape_index(input pos_t p);
    return TAPE_AW'(p + TAPE_HALF);
  endfunction

endpackage

FILE: rtl/tms_ctrl.sv
// ----------------------------------------------------------------------------
// tms_ctrl
// Sequencer of the stepper: walks each item through memory accesses.
// ----------------------------------------------------------------------------
module tms_ctrl import tms_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output logic      out_valid,
  output tms_cmd_t  cmd,
  input  tms_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_RULE1,
    S_EXEC,
    S_TAPE2,
    S_RULE2,
    S_CHECK2,
    S_RESP
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_RESP;
        case (stat.op)
          OP_LOAD:  cmd.load_rule = 1'b1;
          OP_START: cmd.restart = 1'b1;
          OP_STEP: begin
            if (stat.running) begin
              cmd.tape_rd_head = 1'b1;
              state_nxt        = S_RULE1;
            end
          end
          OP_READ:  cmd.tape_rd_pos = 1'b1;
          default:  ;
        endcase
      end
      S_RULE1: begin
        cmd.rule_rd1 = 1'b1;
        state_nxt    = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec_step = 1'b1;
        state_nxt     = stat.need_second ? S_TAPE2 : S_RESP;
      end
      S_TAPE2: begin
        cmd.tape_rd_head = 1'b1;
        state_nxt        = S_RULE2;
      end
      S_RULE2: begin
        cmd.rule_rd2 = 1'b1;
        state_nxt    = S_CHECK2;
      end
      S_CHECK2: begin
        cmd.check2 = 1'b1;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        cmd.respond = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_RESP);
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: rtl/tms_dpath.sv
// ----------------------------------------------------------------------------
// tms_dpath
// Datapath of the stepper: rule and tape memories, machine registers,
// step evaluation and result registers.
// ----------------------------------------------------------------------------
module tms_dpath import tms_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tms_cmd_t                 cmd,
  output tms_stat_t                stat,
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic [1:0]               in_opcode,
  input  logic [STATE_W-1:0]       in_entry_state,
  input  logic [SYM_W-1:0]         in_entry_symbol,
  input  logic [STATE_W-1:0]       in_entry_next_state,
  input  logic                     in_entry_halts,
  input  logic [SYM_W-1:0]         in_entry_write,
  input  logic                     in_entry_right,
  input  logic signed [POS_W-1:0]  in_cell_position,
  output logic [2:0]               out_status,
  output logic [STATE_W-1:0]       out_current_state,
  output logic signed [POS_W-1:0]  out_head_at,
  output logic signed [POS_W-1:0]  out_leftmost,
  output logic [POS_W-2:0]         out_rightmost,
  output logic [SYM_W-1:0]         out_cell_value
);

  // Captured item.
  opcode_t            op_r;
  logic [STATE_W-1:0] ent_state_r;
  logic [SYM_W-1:0]   ent_sym_r;
  rule_t              ent_rule_r;
  pos_t               pos_r;

  // Machine state.
  logic [STATE_W-1:0] state_r, state_nxt;
  pos_t               head_r, head_nxt;
  pos_t               low_r, low_nxt;
  pos_t               high_r, high_nxt;
  logic [CNT_W-1:0]   run_r, run_nxt;
  logic               fresh_r, fresh_nxt;
  status_t            status_r, status_nxt;

  // Configuration.
  logic [CNT_W-1:0]   scount_r;
  logic [SYM_W-1:0]   blank_r;

  // Values kept between the first and the second lookup.
  logic [SYM_W-1:0]   s1_r, s2_r;
  logic [STATE_W-1:0] st1_r;
  logic               right_r;

  // Memories.
  logic [RULE_W-1:0]  rule_mem [RULE_DEPTH];
  logic [RULE_W-1:0]  rule_q_r;
  logic [SYM_W-1:0]   tape_mem [TAPE_CELLS];
  logic [SYM_W-1:0]   tape_q_r;

  logic [RULE_AW-1:0] rule_addr;
  logic [TAPE_AW-1:0] tape_addr;
  logic [SYM_W-1:0]   s_sel;
  rule_t              tr;
  pos_t               np;
  logic               exhaust, newcell, short_esc, long_esc, two_cyc;
  logic [CNT_W-1:0]   run_inc;
  logic               cell_blank;
  logic [SYM_W-1:0]   cell_val;

  // The symbol under the head: a cell just reached for the first time is blank.
  assign s_sel     = fresh_r ? blank_r : tape_q_r;
  assign rule_addr = cmd.load_rule ? {ent_state_r, ent_sym_r} : {state_r, s_sel};
  assign tape_addr = cmd.tape_rd_pos ? tape_index(pos_r) : tape_index(head_r);

  always_ff @(posedge clk) begin
    if (cmd.load_rule) begin
      rule_mem[rule_addr] <= ent_rule_r;
    end else if (cmd.rule_rd1 || cmd.rule_rd2) begin
      rule_q_r <= rule_mem[rule_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_step) begin
      tape_mem[tape_addr] <= tr.wsym;
    end else if (cmd.tape_rd_head || cmd.tape_rd_pos) begin
      tape_q_r <= tape_mem[tape_addr];
    end
  end

  // Step evaluation from the fetched rule.
  always_comb begin
    tr        = rule_t'(rule_q_r);
    exhaust   = tr.right ? (head_r == POS_HIGH) : (head_r == POS_LOW);
    np        = tr.right ? pos_t'(head_r + pos_t'(1)) : pos_t'(head_r - pos_t'(1));
    newcell   = tr.right ? (np > high_r) : (np < low_r);
    run_inc   = (run_r == RUN_MAX) ? run_r : CNT_W'(run_r + 1'b1);
    short_esc = (s1_r == blank_r) && (tr.next_state == state_r);
    long_esc  = (run_inc > scount_r);
    two_cyc   = !tr.halts && (tr.next_state == st1_r) && (tr.wsym == s2_r) &&
                (tr.right != right_r);
  end

  assign stat.op          = op_r;
  assign stat.running     = (status_r == ST_RUNNING);
  assign stat.need_second = !tr.halts && !exhaust && !(newcell && (short_esc || long_esc)) &&
                            (tr.wsym == s1_r);

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    low_nxt    = low_r;
    high_nxt   = high_r;
    run_nxt    = run_r;
    fresh_nxt  = fresh_r;
    status_nxt = status_r;
    if (cmd.restart) begin
      state_nxt  = '0;
      head_nxt   = '0;
      low_nxt    = '0;
      high_nxt   = '0;
      run_nxt    = '0;
      fresh_nxt  = 1'b1;
      status_nxt = ST_RUNNING;
    end
    if (cmd.exec_step) begin
      fresh_nxt = 1'b0;
      if (tr.halts) begin
        status_nxt = ST_HALTED;
      end else begin
        state_nxt = tr.next_state;
        if (exhaust) begin
          status_nxt = ST_EXHAUSTED;
        end else begin
          head_nxt = np;
          if (newcell) begin
            if (tr.right) begin
              high_nxt = np;
            end else begin
              low_nxt = np;
            end
            fresh_nxt = 1'b1;
            run_nxt   = run_inc;
            if (short_esc) begin
              status_nxt = ST_SHORT_ESC;
            end else if (long_esc) begin
              status_nxt = ST_LONG_ESC;
            end
          end else begin
            run_nxt = '0;
          end
        end
      end
    end
    if (cmd.check2 && two_cyc) begin
      status_nxt = ST_TWO_CYCLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= '0;
      head_r   <= '0;
      low_r    <= '0;
      high_r   <= '0;
      run_r    <= '0;
      fresh_r  <= 1'b1;
      status_r <= ST_RUNNING;
      scount_r <= CNT_W'(2);
      blank_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      low_r    <= low_nxt;
      high_r   <= high_nxt;
      run_r    <= run_nxt;
      fresh_r  <= fresh_nxt;
      status_r <= status_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_STATE_COUNT: scount_r <= cfg_wdata;
          CFG_BLANK:       blank_r  <= cfg_wdata[SYM_W-1:0];
          default:         ;
        endcase
      end
    end
  end

  // Cell read: outside the visited span, or the fresh cell under the head, is blank.
  assign cell_blank = (pos_r < low_r) || (pos_r > high_r) || ((pos_r == head_r) && fresh_r);
  assign cell_val   = cell_blank ? blank_r : tape_q_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r                  <= opcode_t'(in_opcode);
      ent_state_r           <= in_entry_state;
      ent_sym_r             <= in_entry_symbol;
      ent_rule_r.next_state <= in_entry_next_state;
      ent_rule_r.halts      <= in_entry_halts;
      ent_rule_r.wsym       <= in_entry_write;
      ent_rule_r.right      <= in_entry_right;
      pos_r                 <= in_cell_position;
    end
    if (cmd.rule_rd1) begin
      s1_r <= s_sel;
    end
    if (cmd.rule_rd2) begin
      s2_r <= s_sel;
    end
    if (cmd.exec_step) begin
      st1_r   <= state_r;
      right_r <= tr.right;
    end
    if (cmd.respond) begin
      out_status        <= status_r;
      out_current_state <= state_r;
      out_head_at       <= head_r;
      out_leftmost      <= low_r;
      out_rightmost     <= high_r[POS_W-2:0];
      out_cell_value    <= (op_r == OP_READ) ? cell_val : '0;
    end
  end

endmodule

FILE: rtl/turing_machine_step_with_loop_detect_top.sv
// ----------------------------------------------------------------------------
// turing_machine_step_with_loop_detect_top
// Turing machine stepper with escapee detection and detection of loops of order two.
// An item is taken at a clock edge with start high and busy low. Its opcode
// loads a rule table entry, restarts the machine, takes one step or reads one
// tape cell. Every item gives exactly one result: out_valid is high for one
// cycle with the status, state, head, visited span and cell value.
// Load, start, read and a step of a stopped machine only dispatch and respond;
// a step also reads the rule table and executes, and may then look ahead one
// transition for a cycle of order two (tape read, rule read, check). The result
// strobe follows in the next cycle, with busy low, so a new start can be taken
// while it is high. The rule and tape memories are single-port: each step reads
// the tape, then the rule table, then writes the tape, in separate cycles.
// Reset clears the machine registers and sets state_count to 2 and blank to 0;
// the rule table and tape are not cleared, since fresh cells read as blank.
// The receiver cannot stall: each transfer on the result side is taken at once.
// Configuration writes are taken at any edge out of reset with cfg_we high.
// ----------------------------------------------------------------------------
`include "turing_machine_step_with_loop_detect_top_assert.svh"

module turing_machine_step_with_loop_detect_top import tms_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // Configuration port.
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  // Command channel.
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_opcode,
  input  logic [STATE_W-1:0]       in_entry_state,
  input  logic [SYM_W-1:0]         in_entry_symbol,
  input  logic [STATE_W-1:0]       in_entry_next_state,
  input  logic                     in_entry_halts,
  input  logic [SYM_W-1:0]         in_entry_write,
  input  logic                     in_entry_right,
  input  logic signed [POS_W-1:0]  in_cell_position,
  // Result channel.
  output logic                     out_valid,
  output logic [2:0]               out_status,
  output logic [STATE_W-1:0]       out_current_state,
  output logic signed [POS_W-1:0]  out_head_at,
  output logic signed [POS_W-1:0]  out_leftmost,
  output logic [POS_W-2:0]         out_rightmost,
  output logic [SYM_W-1:0]         out_cell_value
);

  tms_cmd_t  cmd;
  tms_stat_t stat;

  // The sequencer owns the handshake and the result strobe.
  tms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  // The datapath holds the memories, machine registers and result registers.
  tms_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_opcode           (in_opcode),
    .in_entry_state      (in_entry_state),
    .in_entry_symbol     (in_entry_symbol),
    .in_entry_next_state (in_entry_next_state),
    .in_entry_halts      (in_entry_halts),
    .in_entry_write      (in_entry_write),
    .in_entry_right      (in_entry_right),
    .in_cell_position    (in_cell_position),
    .out_status          (out_status),
    .out_current_state   (out_current_state),
    .out_head_at         (out_head_at),
    .out_leftmost        (out_leftmost),
    .out_rightmost       (out_rightmost),
    .out_cell_value      (out_cell_value)
  );

  // An accepted item always keeps the block busy in the following cycle.
  `TMS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // A result is only presented once the item's work is complete.
  `TMS_ASSERT_NOW(a_result_idle, out_valid, !busy)
  // One item gives one result: the strobe drops again after each result.
  `TMS_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)
  // The left edge of the visited span never lies right of the origin.
  `TMS_ASSERT_NOW(a_left_mark, out_valid, out_leftmost <= 0)

endmodule
